// File: src/jcs_pkg.sv
// Shared types and constants for the JSONC comment stripper.
`default_nettype none

package jcs_pkg;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_STRING = 2'd1;
    localparam logic [1:0] MODE_LINE   = 2'd2;
    localparam logic [1:0] MODE_BLOCK  = 2'd3;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One queued request: the results caused by one input byte.
    typedef struct packed {
        logic [7:0] byte0;
        logic       has0;
        logic [7:0] byte1;
        logic       two;
        logic       eot;
    } jcs_entry_t;

endpackage

`default_nettype wire

// File: src/jsonc_comment_stripper_core.sv
// Top level of the JSONC comment stripper: front end, entry queue and output stage.
// Path: a kept byte is written into the entry queue when its request is accepted, then loaded into the output register.
// Throughput: one input byte per cycle while the queue is not full; a byte that causes two results
// holds the output stage for both of them, and the four-entry queue absorbs such bursts.
// Reset: asynchronous, active low; clears the lexical state, the queue and the output.
`default_nettype none

module jsonc_comment_stripper_core
    import jcs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_byte,
    input  wire logic       last,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic [7:0]      out_byte,
    output logic            has_byte,
    output logic            end_of_text,
    output logic            out_valid,
    input  wire logic       out_ready
);

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_not_empty;
    jcs_entry_t q_in;
    jcs_entry_t q_head;

    jcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_byte),
        .last       (last),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (q_in)
    );

    jcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    jcs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

endmodule

`default_nettype wire

// File: src/jcs_front.sv
// Front end: accepts input bytes, tracks the lexical state and builds result entries.
`default_nettype none

module jcs_front
    import jcs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_byte,
    input  wire logic       last,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       q_full,
    output logic            push,
    output jcs_entry_t      push_entry
);

    logic [1:0] mode_reg, mode_next;
    logic       esc_reg, esc_next;
    logic       slash_reg, slash_next;
    logic       star_reg, star_next;

    logic       lead_v;   // held slash released ahead of the byte
    logic       main_v;   // the byte itself is kept
    logic       tail_v;   // slash flushed at the end of the text
    logic       accept;
    logic [1:0] n_res;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        slash_next = slash_reg;
        star_next  = star_reg;
        lead_v     = 1'b0;
        main_v     = 1'b0;
        case (mode_reg)
            MODE_NORMAL:
            begin
                if (slash_reg && in_byte == CH_SLASH)
                begin
                    slash_next = 1'b0;
                    mode_next  = MODE_LINE;
                end
                else if (slash_reg && in_byte == CH_STAR)
                begin
                    slash_next = 1'b0;
                    mode_next  = MODE_BLOCK;
                    star_next  = 1'b0;
                end
                else
                begin
                    lead_v = slash_reg;
                    if (in_byte == CH_QUOTE)
                    begin
                        slash_next = 1'b0;
                        mode_next  = MODE_STRING;
                        esc_next   = 1'b0;
                        main_v     = 1'b1;
                    end
                    else if (in_byte == CH_SLASH)
                    begin
                        slash_next = 1'b1;
                    end
                    else
                    begin
                        slash_next = 1'b0;
                        main_v     = 1'b1;
                    end
                end
            end
            MODE_STRING:
            begin
                main_v = 1'b1;
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                end
                else if (in_byte == CH_BSL)
                begin
                    esc_next = 1'b1;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_LINE:
            begin
                if (in_byte == CH_NL)
                begin
                    mode_next = MODE_NORMAL;
                    main_v    = 1'b1;
                end
            end
            default:
            begin
                if (star_reg && in_byte == CH_SLASH)
                begin
                    mode_next = MODE_NORMAL;
                    star_next = 1'b0;
                end
                else
                begin
                    star_next = (in_byte == CH_STAR);
                end
            end
        endcase
        tail_v = last && slash_next;
    end

    assign n_res = {1'b0, lead_v} + {1'b0, main_v} + {1'b0, tail_v};

    always_comb
    begin
        push_entry.has0  = (n_res != 2'd0);
        push_entry.two   = (n_res == 2'd2);
        push_entry.eot   = last;
        if (lead_v)
        begin
            push_entry.byte0 = CH_SLASH;
        end
        else if (main_v)
        begin
            push_entry.byte0 = in_byte;
        end
        else if (tail_v)
        begin
            push_entry.byte0 = CH_SLASH;
        end
        else
        begin
            push_entry.byte0 = 8'h00;
        end
        push_entry.byte1 = (lead_v && main_v) ? in_byte : CH_SLASH;
    end

    assign push = accept && ((n_res != 2'd0) || last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            esc_reg   <= 1'b0;
            slash_reg <= 1'b0;
            star_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (last)
            begin
                mode_reg  <= MODE_NORMAL;
                esc_reg   <= 1'b0;
                slash_reg <= 1'b0;
                star_reg  <= 1'b0;
            end
            else
            begin
                mode_reg  <= mode_next;
                esc_reg   <= esc_next;
                slash_reg <= slash_next;
                star_reg  <= star_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/jcs_queue.sv
// Short queue of result entries between the front end and the output stage.
`default_nettype none

module jcs_queue
    import jcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire jcs_entry_t  push_entry,
    output logic             full,
    input  wire logic        pop,
    output logic             not_empty,
    output jcs_entry_t       head
);

    jcs_entry_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/jcs_back.sv
// Output stage: unpacks queued entries into single results behind an output register.
`default_nettype none

module jcs_back
    import jcs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_not_empty,
    input  wire jcs_entry_t q_head,
    output logic            q_pop,
    output logic [7:0]      out_byte,
    output logic            has_byte,
    output logic            end_of_text,
    output logic            out_valid,
    input  wire logic       out_ready
);

    logic       valid_reg;
    logic       second_reg;
    logic [7:0] byte_reg, byte_next;
    logic       has_reg, has_next;
    logic       eot_reg, eot_next;
    logic       load;

    assign load  = q_not_empty && (!valid_reg || out_ready);
    // An entry leaves the queue once its final result is loaded.
    assign q_pop = load && (second_reg || !q_head.two);

    always_comb
    begin
        if (second_reg)
        begin
            byte_next = q_head.byte1;
            has_next  = 1'b1;
            eot_next  = q_head.eot;
        end
        else
        begin
            byte_next = q_head.byte0;
            has_next  = q_head.has0;
            eot_next  = q_head.eot && !q_head.two;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            has_reg  <= has_next;
            eot_reg  <= eot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg  <= 1'b1;
                second_reg <= q_head.two && !second_reg;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign has_byte    = has_reg;
    assign end_of_text = eot_reg;

endmodule

`default_nettype wire

// File: verif/jsonc_comment_stripper_checker.sv
// Checker for the JSONC comment stripper: watches both channels, predicts the stripped text and compares.
`timescale 1ns / 100ps

module jsonc_comment_stripper_checker
    import jcs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_byte,
    input  wire logic       last,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic [7:0] out_byte,
    input  wire logic       has_byte,
    input  wire logic       end_of_text,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    output int              errors,
    output int              awaited
);

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       eot;
    } text_result_t;

    text_result_t stripped_q [$];
    text_result_t oldest;

    // Lexer state of the prediction.
    logic [1:0] lex_mode;
    logic       esc_pend;
    logic       slash_held;
    logic       star_prev;

    int mismatch_count = 0;
    int awaited_count = 0;

    assign errors  = mismatch_count;
    assign awaited = awaited_count;

    function void predict_stripped(input logic [7:0] b, input logic fin);
        text_result_t res [2];
        int           n;
        logic         as_normal;
        n = 0;
        as_normal = 1'b0;
        case (lex_mode)
            MODE_NORMAL:
            begin
                if (slash_held)
                begin
                    slash_held = 1'b0;
                    if (b == CH_SLASH)
                        lex_mode = MODE_LINE;
                    else if (b == CH_STAR)
                    begin
                        lex_mode = MODE_BLOCK;
                        star_prev = 1'b0;
                    end
                    else
                    begin
                        // The held slash did not open a comment, so it goes out first.
                        res[n] = '{data: CH_SLASH, has: 1'b1, eot: 1'b0};
                        n++;
                        as_normal = 1'b1;
                    end
                end
                else
                    as_normal = 1'b1;
            end
            MODE_STRING:
            begin
                res[n] = '{data: b, has: 1'b1, eot: 1'b0};
                n++;
                if (esc_pend)
                    esc_pend = 1'b0;
                else if (b == CH_BSL)
                    esc_pend = 1'b1;
                else if (b == CH_QUOTE)
                    lex_mode = MODE_NORMAL;
            end
            MODE_LINE:
            begin
                if (b == CH_NL)
                begin
                    lex_mode = MODE_NORMAL;
                    res[n] = '{data: b, has: 1'b1, eot: 1'b0};
                    n++;
                end
            end
            default:
            begin
                if (star_prev && b == CH_SLASH)
                begin
                    lex_mode = MODE_NORMAL;
                    star_prev = 1'b0;
                end
                else
                    star_prev = (b == CH_STAR);
            end
        endcase

        if (as_normal)
        begin
            if (b == CH_QUOTE)
            begin
                lex_mode = MODE_STRING;
                esc_pend = 1'b0;
                res[n] = '{data: b, has: 1'b1, eot: 1'b0};
                n++;
            end
            else if (b == CH_SLASH)
                slash_held = 1'b1;
            else
            begin
                res[n] = '{data: b, has: 1'b1, eot: 1'b0};
                n++;
            end
        end

        if (fin)
        begin
            if (slash_held)
            begin
                res[n] = '{data: CH_SLASH, has: 1'b1, eot: 1'b0};
                n++;
            end
            // A final byte that keeps nothing still produces a bare end marker.
            if (n == 0)
            begin
                res[n] = '{data: 8'h00, has: 1'b0, eot: 1'b0};
                n++;
            end
            res[n - 1].eot = 1'b1;
            lex_mode = MODE_NORMAL;
            esc_pend = 1'b0;
            slash_held = 1'b0;
            star_prev = 1'b0;
        end

        for (int i = 0; i < n; i++)
            stripped_q.push_back(res[i]);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            lex_mode = MODE_NORMAL;
            esc_pend = 1'b0;
            slash_held = 1'b0;
            star_prev = 1'b0;
            stripped_q.delete();
        end
        else
        begin
            // A result leaving in this cycle can only stem from an earlier request.
            if (out_valid && out_ready)
            begin
                if (stripped_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, got byte %02h has %0b end %0b",
                             $time, out_byte, has_byte, end_of_text);
                end
                else
                begin
                    oldest = stripped_q.pop_front();
                    if (out_byte !== oldest.data)
                    begin
                        mismatch_count++;
                        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                                 $time, oldest.data, out_byte);
                    end
                    if (has_byte !== oldest.has)
                    begin
                        mismatch_count++;
                        $display("%0t: has_byte mismatch, expected %0b, got %0b",
                                 $time, oldest.has, has_byte);
                    end
                    if (end_of_text !== oldest.eot)
                    begin
                        mismatch_count++;
                        $display("%0t: end_of_text mismatch, expected %0b, got %0b",
                                 $time, oldest.eot, end_of_text);
                    end
                end
            end
            if (in_valid && in_ready)
                predict_stripped(in_byte, last);
        end
        awaited_count = stripped_q.size();
    end

endmodule

// File: verif/jsonc_comment_stripper_core_tb.sv
// Testbench top for the JSONC comment stripper: clock, reset, text stimulus and verdict.
`timescale 1ns / 100ps

module jsonc_comment_stripper_core_tb
    import jcs_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    logic       clk;
    logic       rst_n = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       last = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_text;
    logic       out_valid;
    logic       out_ready = 1'b0;

    int errors;
    int awaited;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    bit hold_arm = 1'b0;
    bit hold_done = 1'b0;

    logic [7:0] text_q [$];

    // Bit 8 flags the final byte of a text.
    logic [8:0] directed_seq [25] = '{
        {1'b0, 8'h00},    {1'b0, CH_SLASH}, {1'b0, 8'hFF},    {1'b0, CH_QUOTE},
        {1'b0, CH_BSL},   {1'b0, CH_QUOTE}, {1'b0, CH_SLASH}, {1'b0, CH_QUOTE},
        {1'b0, CH_SLASH}, {1'b0, CH_SLASH}, {1'b0, 8'h78},    {1'b0, CH_NL},
        {1'b0, CH_SLASH}, {1'b0, CH_STAR},  {1'b0, CH_SLASH}, {1'b0, CH_STAR},
        {1'b0, CH_SLASH}, {1'b1, CH_SLASH}, {1'b0, CH_SLASH}, {1'b0, CH_STAR},
        {1'b1, 8'h71},    {1'b0, CH_QUOTE}, {1'b1, 8'h7A},    {1'b0, CH_SLASH},
        {1'b1, CH_SLASH}
    };

    jsonc_comment_stripper_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (in_byte),
        .last        (last),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

    jsonc_comment_stripper_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (in_byte),
        .last        (last),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .errors      (errors),
        .awaited     (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Output side: random stalls, plus one long hold-off that backs the block up.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic offer_byte(input logic [7:0] b, input logic fin);
        logic taken;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        last <= fin;
        // Ready is settled by the falling edge, so the next rising edge takes the request.
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Builds one text from letters, strings, comments, stray slashes and noise bytes.
    task automatic compose_text();
        int         tokens;
        int         pick;
        int         k;
        logic [7:0] c;
        text_q.delete();
        tokens = $urandom_range(1, 8);
        repeat (tokens)
        begin
            pick = $urandom_range(99);
            k = $urandom_range(0, 6);
            if (pick < 30)
                text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
            else if (pick < 45)
            begin
                text_q.push_back(CH_QUOTE);
                repeat (k)
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        text_q.push_back(CH_BSL);
                        text_q.push_back(8'($urandom_range(255)));
                    end
                    else
                    begin
                        c = 8'($urandom_range(255));
                        if (c == CH_QUOTE || c == CH_BSL)
                            c = 8'h41;
                        text_q.push_back(c);
                    end
                end
                text_q.push_back(CH_QUOTE);
            end
            else if (pick < 60)
            begin
                text_q.push_back(CH_SLASH);
                text_q.push_back(CH_SLASH);
                repeat (k)
                begin
                    c = 8'($urandom_range(255));
                    if (c == CH_NL)
                        c = 8'h20;
                    text_q.push_back(c);
                end
                text_q.push_back(CH_NL);
            end
            else if (pick < 75)
            begin
                text_q.push_back(CH_SLASH);
                text_q.push_back(CH_STAR);
                repeat (k)
                begin
                    case ($urandom_range(2))
                        0:       text_q.push_back(CH_STAR);
                        1:       text_q.push_back(CH_SLASH);
                        default: text_q.push_back(8'($urandom_range(255)));
                    endcase
                end
                text_q.push_back(CH_STAR);
                text_q.push_back(CH_SLASH);
            end
            else if (pick < 85)
            begin
                text_q.push_back(CH_SLASH);
                c = 8'($urandom_range(255));
                if (c == CH_SLASH || c == CH_STAR)
                    c = 8'h20;
                text_q.push_back(c);
            end
            else
                text_q.push_back(8'($urandom_range(255)));
        end
        // Now and then the text stops part-way through a construct.
        if ($urandom_range(9) == 0)
        begin
            k = $urandom_range(1, text_q.size());
            while (text_q.size() > k)
                void'(text_q.pop_back());
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int quota);
        int sent;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < quota)
        begin
            compose_text();
            foreach (text_q[i])
                offer_byte(text_q[i], i == text_q.size() - 1);
            sent += text_q.size();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_seq[i])
            offer_byte(directed_seq[i][7:0], directed_seq[i][8]);

        // The long hold-off falls in the phase where the sender never pauses.
        hold_arm = 1'b1;
        run_phase(0, 0, 320);
        run_phase(47, 0, 310);
        run_phase(0, 47, 310);
        run_phase(27, 27, 310);
        in_valid <= 1'b0;

        do
            @(negedge clk);
        while (awaited != 0);
        repeat (10) @(posedge clk);
        @(negedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
src/jcs_pkg.sv
src/jcs_front.sv
src/jcs_queue.sv
src/jcs_back.sv
src/jsonc_comment_stripper_core.sv
verif/jsonc_comment_stripper_checker.sv
verif/jsonc_comment_stripper_core_tb.sv
